// ===== rtl/core/rse_pkg.sv =====
// shared types, constants and helper functions of the postfix set evaluator
`timescale 1ns / 1ps
`default_nettype none
package rse_pkg;

	// stack geometry
	localparam int STACK_DEPTH = 1024;
	localparam int STK_AW = $clog2(STACK_DEPTH);
	localparam int STK_DW = $clog2(STACK_DEPTH + 1);

	// alphabet
	localparam int SET_W = 62;
	localparam int NUM_DIGITS = 10;
	localparam int NUM_LETTERS = 26;
	localparam int IDX_W = $clog2(SET_W);

	typedef logic [SET_W-1:0] set_t;
	typedef logic [IDX_W-1:0] sym_idx_t;

	// character codes
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_BAR   = 8'h7C;
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;

	// stack command codes
	localparam logic [2:0] OP_PUSH = 3'd0;
	localparam logic [2:0] OP_NOT  = 3'd1;
	localparam logic [2:0] OP_AND  = 3'd2;
	localparam logic [2:0] OP_OR   = 3'd3;
	localparam logic [2:0] OP_XOR  = 3'd4;
	localparam logic [2:0] OP_DROP = 3'd5;
	localparam logic [2:0] OP_FIN  = 3'd6;

	typedef struct packed {
		logic [7:0] ch;
		logic       finish;
	} char_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       final_item;
		logic       error;
	} res_item_t;

	typedef struct packed {
		logic [2:0] op;
		set_t       val;
	} stk_cmd_t;

	// bottom entry handed from the stack to the output walker
	typedef struct packed {
		logic valid;
		set_t bits;
		logic err;
	} fin_info_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_UA && c <= CH_UZ) ||
			(c >= CH_LA && c <= CH_LZ);
	endfunction

	// one-hot symbol bit of an alphanumeric byte, zero otherwise
	function automatic set_t sym_bit(input logic [7:0] c);
		logic [7:0] k;
		k = 8'd0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			k = c - CH_ZERO;
		end else if (c >= CH_UA && c <= CH_UZ) begin
			k = c - CH_UA + 8'(NUM_DIGITS);
		end else if (c >= CH_LA && c <= CH_LZ) begin
			k = c - CH_LA + 8'(NUM_DIGITS + NUM_LETTERS);
		end
		return is_alnum(c) ? (set_t'(1) << k[IDX_W-1:0]) : '0;
	endfunction

	function automatic logic [7:0] sym_char(input sym_idx_t idx);
		logic [7:0] i;
		i = 8'(idx);
		if (i < 8'(NUM_DIGITS)) begin
			return CH_ZERO + i;
		end else if (i < 8'(NUM_DIGITS + NUM_LETTERS)) begin
			return CH_UA + (i - 8'(NUM_DIGITS));
		end
		return CH_LA + (i - 8'(NUM_DIGITS + NUM_LETTERS));
	endfunction

	function automatic set_t set_op(input logic [2:0] op, input set_t a, input set_t b);
		case (op)
			OP_OR:   return a | b;
			OP_XOR:  return a ^ b;
			default: return a & b;
		endcase
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/rpn_set_expression_evaluator_top.sv =====
// top level: character decoding, word builder and handshakes of the set evaluator
// Words, '#', '~' and whitespace leave the stack idle; '&', '|', '^' with two or more entries
//   pass through ST_BIN, discards with three or more through ST_REFILL (memory read); else idle.
// Finish: entry 0 is read (state ST_FIN), then one symbol bit is scanned per cycle while the
//   output is not stalled; the closing newline follows, preceded by '#' for an empty set.
// Throughput: one item at a time; input stall is high while an item is in flight.
// Reset: control state clears at once; stack memory is not cleared (no clearing pass).
`timescale 1ns / 1ps
`default_nettype none
module rpn_set_expression_evaluator_top
	import rse_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       char_valid,
	output logic            char_stall,
	input  wire char_item_t char_data,
	output logic            res_valid,
	input  wire logic       res_stall,
	output res_item_t       res_data
);

	logic      stk_busy, emit_busy;
	logic      accept;
	logic      in_word_q, in_word_d;
	set_t      word_q, word_d;
	logic      cmd_valid;
	stk_cmd_t  cmd;
	fin_info_t fin;

	assign char_stall = stk_busy || emit_busy;
	assign accept     = char_valid && !char_stall;

	// character decode and word building
	always_comb begin
		in_word_d = in_word_q;
		word_d    = word_q;
		cmd_valid = 1'b0;
		cmd.op    = OP_PUSH;
		cmd.val   = '0;
		if (accept) begin
			if (char_data.finish) begin
				cmd_valid = 1'b1;
				cmd.op    = OP_FIN;
				in_word_d = 1'b0;
			end else if (in_word_q) begin
				if (is_space(char_data.ch)) begin
					cmd_valid = 1'b1;
					cmd.val   = word_q;
					in_word_d = 1'b0;
				end else begin
					word_d = word_q | sym_bit(char_data.ch);
				end
			end else if (is_alnum(char_data.ch)) begin
				in_word_d = 1'b1;
				word_d    = sym_bit(char_data.ch);
			end else if (!is_space(char_data.ch)) begin
				cmd_valid = 1'b1;
				case (char_data.ch)
					CH_HASH:  cmd.op = OP_PUSH;
					CH_TILDE: cmd.op = OP_NOT;
					CH_AMP:   cmd.op = OP_AND;
					CH_BAR:   cmd.op = OP_OR;
					CH_CARET: cmd.op = OP_XOR;
					default:  cmd.op = OP_DROP;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_word_q <= 1'b0;
		end else begin
			in_word_q <= in_word_d;
		end
	end

	always_ff @(posedge clk) begin
		word_q <= word_d;
	end

	rse_stack u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.busy      (stk_busy),
		.fin       (fin)
	);

	rse_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin       (fin),
		.busy      (emit_busy),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule
`default_nettype wire

// ===== rtl/core/rse_stack.sv =====
// set stack: memory of sets with a cached top entry and read-modify-write sequencing
`timescale 1ns / 1ps
`default_nettype none
module rse_stack
	import rse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	input  wire stk_cmd_t  cmd,
	output logic           busy,
	output fin_info_t      fin
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_BIN    = 2'd1;
	localparam logic [1:0] ST_REFILL = 2'd2;
	localparam logic [1:0] ST_FIN    = 2'd3;

	set_t mem [STACK_DEPTH];

	logic [1:0]        state_q, state_d;
	logic [STK_DW-1:0] depth_q, depth_d;
	logic              err_q, err_d;
	set_t              top_q, top_d;
	set_t              rd_q;
	logic [2:0]        op_s1, op_d;
	logic [STK_AW-1:0] waddr_s1, waddr_d;

	logic              we, re;
	logic [STK_AW-1:0] waddr, raddr;
	set_t              wdata;
	logic              empty, full;
	set_t              top_v, res;

	assign empty = (depth_q == '0);
	assign full  = (depth_q == STK_DW'(STACK_DEPTH));
	assign top_v = empty ? '0 : top_q;

	// command sequencing
	always_comb begin
		state_d = state_q;
		depth_d = depth_q;
		err_d   = err_q;
		top_d   = top_q;
		op_d    = op_s1;
		waddr_d = waddr_s1;
		we      = 1'b0;
		re      = 1'b0;
		waddr   = '0;
		raddr   = '0;
		wdata   = '0;
		res     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op) inside
						OP_PUSH: begin
							if (full) begin
								err_d = 1'b1;
							end else begin
								we      = 1'b1;
								waddr   = depth_q[STK_AW-1:0];
								wdata   = cmd.val;
								top_d   = cmd.val;
								depth_d = depth_q + STK_DW'(1);
							end
						end
						OP_NOT: begin
							res   = ~top_v;
							we    = 1'b1;
							waddr = empty ? '0 : STK_AW'(depth_q - STK_DW'(1));
							wdata = res;
							top_d = res;
							if (empty) begin
								err_d   = 1'b1;
								depth_d = STK_DW'(1);
							end
						end
						OP_AND, OP_OR, OP_XOR: begin
							if (depth_q >= STK_DW'(2)) begin
								// second entry comes from memory next cycle
								re      = 1'b1;
								raddr   = STK_AW'(depth_q - STK_DW'(2));
								waddr_d = STK_AW'(depth_q - STK_DW'(2));
								op_d    = cmd.op;
								state_d = ST_BIN;
							end else begin
								// underflow: missing operands read as empty
								res     = set_op(cmd.op, top_v, '0);
								we      = 1'b1;
								wdata   = res;
								top_d   = res;
								err_d   = 1'b1;
								depth_d = STK_DW'(1);
							end
						end
						OP_DROP: begin
							if (depth_q >= STK_DW'(3)) begin
								re      = 1'b1;
								raddr   = STK_AW'(depth_q - STK_DW'(3));
								depth_d = depth_q - STK_DW'(2);
								state_d = ST_REFILL;
							end else begin
								err_d   = err_q | (depth_q < STK_DW'(2));
								depth_d = '0;
							end
						end
						OP_FIN: begin
							re      = 1'b1;
							state_d = ST_FIN;
						end
						default: begin
							state_d = ST_IDLE;
						end
					endcase
				end
			end
			ST_BIN: begin
				res     = set_op(op_s1, top_q, rd_q);
				we      = 1'b1;
				waddr   = waddr_s1;
				wdata   = res;
				top_d   = res;
				depth_d = depth_q - STK_DW'(1);
				state_d = ST_IDLE;
			end
			ST_REFILL: begin
				top_d   = rd_q;
				state_d = ST_IDLE;
			end
			ST_FIN: begin
				depth_d = '0;
				err_d   = 1'b0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			depth_q <= '0;
			err_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			depth_q <= depth_d;
			err_q   <= err_d;
		end
	end

	// cached top and pending operation
	always_ff @(posedge clk) begin
		top_q    <= top_d;
		op_s1    <= op_d;
		waddr_s1 <= waddr_d;
	end

	// stack memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	assign busy      = (state_q != ST_IDLE);
	assign fin.valid = (state_q == ST_FIN);
	assign fin.bits  = rd_q;
	assign fin.err   = err_q;

	a_cmd_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (state_q == ST_IDLE))
		else $error("stack command while an operation is in flight");

	a_depth_range: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= STK_DW'(STACK_DEPTH))
		else $error("stack depth beyond capacity");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |=> (depth_q == '0 && !err_q))
		else $error("finish did not clear the stack state");

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(we && re && (waddr == raddr)))
		else $error("read and write of one entry in the same cycle");

endmodule
`default_nettype wire

// ===== rtl/core/rse_emit.sv =====
// output walker: scans the bottom set one symbol per cycle, while the output is not stalled, into the result register
`timescale 1ns / 1ps
`default_nettype none
module rse_emit
	import rse_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire fin_info_t fin,
	output logic           busy,
	output logic           res_valid,
	input  wire logic      res_stall,
	output res_item_t      res_data
);

	localparam logic [1:0] PH_WALK = 2'd0;
	localparam logic [1:0] PH_HASH = 2'd1;
	localparam logic [1:0] PH_NL   = 2'd2;

	logic       busy_q, busy_d;
	logic [1:0] phase_q, phase_d;
	logic       ov_q;
	res_item_t  od_q;
	set_t       set_q;
	sym_idx_t   idx_q;
	logic       any_q, err_q;

	logic       out_free, load, ld_final;
	logic [7:0] ld_char;

	assign out_free = !ov_q || !res_stall;

	// next symbol, hash or newline
	always_comb begin
		busy_d   = busy_q;
		phase_d  = phase_q;
		load     = 1'b0;
		ld_char  = CH_NL;
		ld_final = 1'b0;
		if (busy_q && out_free) begin
			unique case (phase_q)
				PH_WALK: begin
					if (set_q[idx_q]) begin
						load    = 1'b1;
						ld_char = sym_char(idx_q);
					end
					if (idx_q == sym_idx_t'(SET_W - 1)) begin
						phase_d = (any_q || set_q[idx_q]) ? PH_NL : PH_HASH;
					end
				end
				PH_HASH: begin
					load    = 1'b1;
					ld_char = CH_HASH;
					phase_d = PH_NL;
				end
				PH_NL: begin
					load     = 1'b1;
					ld_final = 1'b1;
					busy_d   = 1'b0;
				end
				default: begin
					phase_d = PH_NL;
				end
			endcase
		end
		if (fin.valid) begin
			busy_d  = 1'b1;
			phase_d = PH_WALK;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_WALK;
			ov_q    <= 1'b0;
		end else begin
			busy_q  <= busy_d;
			phase_q <= phase_d;
			ov_q    <= load || (ov_q && res_stall);
		end
	end

	// walker payload and result register
	always_ff @(posedge clk) begin
		if (fin.valid) begin
			set_q <= fin.bits;
			err_q <= fin.err;
			idx_q <= '0;
			any_q <= 1'b0;
		end else if (busy_q && out_free && phase_q == PH_WALK) begin
			idx_q <= idx_q + sym_idx_t'(1);
			any_q <= any_q | set_q[idx_q];
		end
		if (load) begin
			od_q.out_char   <= ld_char;
			od_q.final_item <= ld_final;
			od_q.error      <= err_q;
		end
	end

	assign busy      = busy_q;
	assign res_valid = ov_q;
	assign res_data  = od_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && res_stall) |-> !load)
		else $error("result register overwritten while stalled");

	a_fin_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin.valid |-> !busy_q)
		else $error("new finish while the walker is busy");

	a_final_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && ld_final) |=> !busy_q)
		else $error("walker still busy after the closing newline");

endmodule
`default_nettype wire
